### rtl/core/msbs_pkg.sv
// Shared types and constants for the masked byte signature scanner.
// No dependencies.
`default_nettype none

package msbs_pkg;

    localparam int NUM_PATTERNS_DEF    = 4;
    localparam int MAX_PATTERN_LEN_DEF = 8;
    localparam int OFFSET_BITS_DEF     = 32;

    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int CTRL_W       = 12;
    localparam int SIG_BYTES    = 8;
    localparam int WILD_LSB     = 0;
    localparam int LEN_LSB      = 8;
    localparam int LEN_FIELD_W  = 4;
    localparam int OUT_OFFSET_W = 32;
    localparam int OUT_PIDX_W   = 2;

    localparam logic [7:0] FILL_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_start;
    } t_in_item;

    typedef struct packed {
        logic [OUT_OFFSET_W-1:0] match_offset;
        logic [OUT_PIDX_W-1:0]   pattern_index;
        logic                    last_of_run;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### rtl/core/msbs_front.sv
// Front end: byte window, buffer byte count and per-pattern masked compare.
// Pushes a match mask and count into the queue. Depends on msbs_pkg.
`default_nettype none

module msbs_front #(
    parameter int NUM_PATTERNS    = msbs_pkg::NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF,
    parameter int OFFSET_BITS     = msbs_pkg::OFFSET_BITS_DEF,
    parameter int LEN_W           = $clog2(MAX_PATTERN_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  msbs_pkg::t_in_item      i_in_data,
    output logic                    o_in_stall,
    input  logic [7:0]              i_sig [NUM_PATTERNS][MAX_PATTERN_LEN],
    input  logic [MAX_PATTERN_LEN-1:0] i_wild [NUM_PATTERNS],
    input  logic [LEN_W-1:0]        i_len [NUM_PATTERNS],
    input  msbs_pkg::t_q_stat       i_q_stat,
    output logic                    o_push,
    output logic [NUM_PATTERNS-1:0] o_push_mask,
    output logic [OFFSET_BITS-1:0]  o_push_cnt
);
    import msbs_pkg::*;

    localparam int WIN_W = $clog2(MAX_PATTERN_LEN);

    logic [7:0]             r_win [MAX_PATTERN_LEN];
    logic [7:0]             n_win [MAX_PATTERN_LEN];
    logic [OFFSET_BITS-1:0] r_cnt;
    logic [OFFSET_BITS-1:0] n_cnt;
    logic [OFFSET_BITS-1:0] base_cnt;
    logic [NUM_PATTERNS-1:0] match;
    logic [LEN_W-1:0]       k;
    logic                   accept;

    always_comb begin
        accept   = i_in_valid && !i_q_stat.full;
        n_win[0] = i_in_data.data_byte;
        for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
            n_win[i] = i_in_data.buffer_start ? FILL_BYTE : r_win[i-1];
        end
        base_cnt = i_in_data.buffer_start ? '0 : r_cnt;
        n_cnt    = (&base_cnt) ? base_cnt : base_cnt + OFFSET_BITS'(1);
        k        = '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            match[p] = (i_len[p] != '0) && (n_cnt >= OFFSET_BITS'(i_len[p]));
            for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
                if (LEN_W'(j) < i_len[p]) begin
                    k = i_len[p] - LEN_W'(1) - LEN_W'(j);
                    if (!i_wild[p][j] && (n_win[k[WIN_W-1:0]] != i_sig[p][j])) begin
                        match[p] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                r_win[i] <= FILL_BYTE;
            end
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_win <= n_win;
        end
    end

    assign o_in_stall  = i_q_stat.full;
    assign o_push      = accept && (|match);
    assign o_push_mask = match;
    assign o_push_cnt  = n_cnt;

endmodule

`default_nettype wire

### rtl/core/msbs_fifo.sv
// Short register queue between front and back ends.
// Depends on msbs_pkg for the status struct.
`default_nettype none

module msbs_fifo #(
    parameter int WIDTH = 36,
    parameter int DEPTH = msbs_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_rdata,
    output msbs_pkg::t_q_stat o_stat
);
    import msbs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

### rtl/core/msbs_back.sv
// Back end: splits a queued match mask into results, lowest pattern first,
// and holds them in the output register. Depends on msbs_pkg.
`default_nettype none

module msbs_back #(
    parameter int NUM_PATTERNS    = msbs_pkg::NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF,
    parameter int OFFSET_BITS     = msbs_pkg::OFFSET_BITS_DEF,
    parameter int LEN_W           = $clog2(MAX_PATTERN_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  msbs_pkg::t_q_stat       i_q_stat,
    input  logic [NUM_PATTERNS-1:0] i_head_mask,
    input  logic [OFFSET_BITS-1:0]  i_head_cnt,
    input  logic [LEN_W-1:0]        i_len [NUM_PATTERNS],
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output msbs_pkg::t_out_item     o_out_data
);
    import msbs_pkg::*;

    localparam int PIDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_data, n_out_data;
    logic                    r_rem_valid, n_rem_valid;
    logic [NUM_PATTERNS-1:0] r_rem_mask, n_rem_mask;
    logic [OFFSET_BITS-1:0]  r_rem_cnt, n_rem_cnt;

    logic                    load, cur_valid, found;
    logic [NUM_PATTERNS-1:0] cur_mask, onehot, rest;
    logic [OFFSET_BITS-1:0]  cur_cnt, offset;
    logic [PIDX_W-1:0]       sel;
    logic [OFFSET_BITS+OUT_OFFSET_W-1:0] off_ext;
    logic [PIDX_W+OUT_PIDX_W-1:0]        pidx_ext;

    always_comb begin
        load      = !r_out_valid || !i_out_stall;
        cur_valid = r_rem_valid || !i_q_stat.empty;
        cur_mask  = r_rem_valid ? r_rem_mask : i_head_mask;
        cur_cnt   = r_rem_valid ? r_rem_cnt : i_head_cnt;

        found  = 1'b0;
        sel    = '0;
        onehot = '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (!found && cur_mask[p]) begin
                found     = 1'b1;
                sel       = PIDX_W'(p);
                onehot[p] = 1'b1;
            end
        end
        rest     = cur_mask & ~onehot;
        offset   = cur_cnt - OFFSET_BITS'(i_len[sel]);
        off_ext  = {{OUT_OFFSET_W{1'b0}}, offset};
        pidx_ext = {{OUT_PIDX_W{1'b0}}, sel};

        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_rem_valid = r_rem_valid;
        n_rem_mask  = r_rem_mask;
        n_rem_cnt   = r_rem_cnt;
        o_pop       = 1'b0;

        if (load) begin
            n_out_valid = cur_valid;
            if (cur_valid) begin
                n_out_data.match_offset  = off_ext[OUT_OFFSET_W-1:0];
                n_out_data.pattern_index = pidx_ext[OUT_PIDX_W-1:0];
                n_out_data.last_of_run   = (rest == '0);
                o_pop       = !r_rem_valid;
                n_rem_valid = (rest != '0);
                n_rem_mask  = rest;
                n_rem_cnt   = cur_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rem_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_rem_valid <= n_rem_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_rem_mask <= n_rem_mask;
        r_rem_cnt  <= n_rem_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/core/masked_byte_signature_scanner.sv
// Masked byte signature scanner, top level: config registers, front, queue, back.
// Path: a matching byte's mask and count enter the match queue; each result is then
// registered in the output register, one per cycle while i_out_stall is low.
// Throughput: one byte per cycle unless the queue is full; a byte with k matches
// gives k results, and input stalls only while the four-entry match queue is full.
// Reset: synchronous, active low; clears patterns (all disabled), window, count, queue.
`default_nettype none

module masked_byte_signature_scanner #(
    parameter int NUM_PATTERNS    = msbs_pkg::NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = msbs_pkg::MAX_PATTERN_LEN_DEF,
    parameter int OFFSET_BITS     = msbs_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_W          = $clog2(2 * NUM_PATTERNS) + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  msbs_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output msbs_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_W-1:0]               paddr,
    input  logic [msbs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [msbs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import msbs_pkg::*;

    localparam int IDX_W     = ADDR_W - 3;
    localparam int LEN_W     = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PAD_BYTES = (MAX_PATTERN_LEN > SIG_BYTES) ? MAX_PATTERN_LEN : SIG_BYTES;
    localparam int Q_W       = NUM_PATTERNS + OFFSET_BITS;

    logic [CFG_DATA_W-1:0] r_sig  [NUM_PATTERNS];
    logic [CTRL_W-1:0]     r_ctrl [NUM_PATTERNS];

    logic [7:0]                 cfg_sig  [NUM_PATTERNS][MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] cfg_wild [NUM_PATTERNS];
    logic [LEN_W-1:0]           cfg_len  [NUM_PATTERNS];
    logic [8*PAD_BYTES-1:0]     sig_ext;
    logic [PAD_BYTES-1:0]       wild_ext;
    logic [LEN_FIELD_W-1:0]     len_field;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    logic                    q_push, q_pop;
    logic [NUM_PATTERNS-1:0] push_mask;
    logic [OFFSET_BITS-1:0]  push_cnt;
    logic [Q_W-1:0]          q_head;
    t_q_stat                 q_stat;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_sig[p]  <= '0;
                r_ctrl[p] <= '0;
            end
        end else if (cfg_wr) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                if (cfg_idx == IDX_W'(2 * p)) begin
                    r_sig[p] <= pwdata;
                end
                if (cfg_idx == IDX_W'(2 * p + 1)) begin
                    r_ctrl[p] <= pwdata[CTRL_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (cfg_idx == IDX_W'(2 * p)) begin
                prdata = r_sig[p];
            end
            if (cfg_idx == IDX_W'(2 * p + 1)) begin
                prdata = CFG_DATA_W'(r_ctrl[p]);
            end
        end
    end

    // signature bytes and wildcard bits past the signature word read as zero
    always_comb begin
        sig_ext   = '0;
        wild_ext  = '0;
        len_field = '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            sig_ext                 = '0;
            sig_ext[CFG_DATA_W-1:0] = r_sig[p];
            wild_ext                = '0;
            wild_ext[SIG_BYTES-1:0] = r_ctrl[p][WILD_LSB +: SIG_BYTES];
            for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
                cfg_sig[p][j]  = sig_ext[8*j +: 8];
                cfg_wild[p][j] = wild_ext[j];
            end
            len_field = r_ctrl[p][LEN_LSB +: LEN_FIELD_W];
            if (32'(len_field) > 32'(MAX_PATTERN_LEN)) begin
                cfg_len[p] = LEN_W'(MAX_PATTERN_LEN);
            end else begin
                cfg_len[p] = LEN_W'(len_field);
            end
        end
    end

    msbs_front #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .OFFSET_BITS     (OFFSET_BITS),
        .LEN_W           (LEN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_sig       (cfg_sig),
        .i_wild      (cfg_wild),
        .i_len       (cfg_len),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_mask (push_mask),
        .o_push_cnt  (push_cnt)
    );

    msbs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({push_mask, push_cnt}),
        .i_pop   (q_pop),
        .o_rdata (q_head),
        .o_stat  (q_stat)
    );

    msbs_back #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .OFFSET_BITS     (OFFSET_BITS),
        .LEN_W           (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head_mask (q_head[Q_W-1:OFFSET_BITS]),
        .i_head_cnt  (q_head[OFFSET_BITS-1:0]),
        .i_len       (cfg_len),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("match pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("match queue popped while empty");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("result run broken before its last result");

endmodule

`default_nettype wire

### dv/msbs_match_checker.sv
// Match checker for the masked byte signature scanner: mirrors the pattern registers from
// the config port, predicts the match results of each accepted byte and compares them.
// Depends on msbs_pkg.
module msbs_match_checker #(
    parameter int ADDR_W = $clog2(2 * msbs_pkg::NUM_PATTERNS_DEF) + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  msbs_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  msbs_pkg::t_out_item             i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [ADDR_W-1:0]               i_paddr,
    input  logic [msbs_pkg::CFG_DATA_W-1:0] i_pwdata,
    input  logic [msbs_pkg::CFG_DATA_W-1:0] i_prdata,
    input  logic                            i_pready,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_match_count,
    output int                              o_bytes
);
    timeunit 1ns;
    timeprecision 1ps;
    import msbs_pkg::*;

    localparam int NUM_PAT   = NUM_PATTERNS_DEF;
    localparam int MAX_LEN   = MAX_PATTERN_LEN_DEF;
    localparam int COUNT_W   = OFFSET_BITS_DEF;
    localparam int REG_BYTES = 8;
    localparam int SIG_SEL   = 0;
    localparam int CTRL_SEL  = 1;

    logic [CFG_DATA_W-1:0] sig_word  [NUM_PAT];
    logic [CTRL_W-1:0]     ctrl_word [NUM_PAT];
    logic [7:0]            byte_win  [MAX_LEN];
    logic [COUNT_W-1:0]    bytes_seen;
    t_out_item             match_q   [$];
    int                    errors;
    int                    match_count;
    int                    bytes_in;

    function automatic void scan_byte(t_in_item it);
        t_out_item found [$];
        t_out_item m;
        int        len;
        bit        hit;
        if (it.buffer_start) begin
            foreach (byte_win[i]) byte_win[i] = FILL_BYTE;
            bytes_seen = '0;
        end
        for (int i = MAX_LEN - 1; i > 0; i--) byte_win[i] = byte_win[i-1];
        byte_win[0] = it.data_byte;
        if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
        for (int p = 0; p < NUM_PAT; p++) begin
            len = int'(ctrl_word[p][LEN_LSB +: LEN_FIELD_W]);
            if (len > MAX_LEN) len = MAX_LEN;
            if (len == 0 || bytes_seen < COUNT_W'(len)) continue;
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
                if (!ctrl_word[p][WILD_LSB + j] && byte_win[len-1-j] != sig_word[p][8*j +: 8])
                    hit = 1'b0;
            end
            if (hit) begin
                m.match_offset  = OUT_OFFSET_W'(bytes_seen - COUNT_W'(len));
                m.pattern_index = OUT_PIDX_W'(p);
                m.last_of_run   = 1'b0;
                found = {found, m};
            end
        end
        foreach (found[k]) begin
            m = found[k];
            m.last_of_run = (k == found.size() - 1);
            match_q = {match_q, m};
        end
    endfunction

    always @(posedge i_clk) begin
        int                    idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_out_item             want;
        if (!i_rst_n) begin
            foreach (sig_word[p]) begin
                sig_word[p]  = '0;
                ctrl_word[p] = '0;
            end
            foreach (byte_win[i]) byte_win[i] = FILL_BYTE;
            bytes_seen = '0;
            match_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                idx = int'(i_paddr) / REG_BYTES;
                if (idx < 2 * NUM_PAT) begin
                    reg_val = (idx % 2 == SIG_SEL) ? sig_word[idx/2]
                                                   : CFG_DATA_W'(ctrl_word[idx/2]);
                    if (i_pwrite) begin
                        if (idx % 2 == CTRL_SEL) ctrl_word[idx/2] = i_pwdata[CTRL_W-1:0];
                        else sig_word[idx/2] = i_pwdata;
                    end else if (i_prdata !== reg_val) begin
                        errors++;
                        $display("%t register %0d read: expected %h, got %h",
                                 $realtime, idx, reg_val, i_prdata);
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (match_q.size() == 0) begin
                    errors++;
                    $display({"%t unexpected match: expected none, ",
                              "got offset %h pattern %0d last %b"},
                             $realtime, i_out_data.match_offset, i_out_data.pattern_index,
                             i_out_data.last_of_run);
                end else begin
                    want = match_q.pop_front();
                    match_count++;
                    if (want.match_offset !== i_out_data.match_offset ||
                        want.pattern_index !== i_out_data.pattern_index ||
                        want.last_of_run !== i_out_data.last_of_run) begin
                        errors++;
                        $display({"%t match mismatch: expected offset %h pattern %0d last %b, ",
                                  "got offset %h pattern %0d last %b"},
                                 $realtime, want.match_offset, want.pattern_index,
                                 want.last_of_run, i_out_data.match_offset,
                                 i_out_data.pattern_index, i_out_data.last_of_run);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                bytes_in++;
                scan_byte(i_in_data);
            end
        end
        o_errors      <= errors;
        o_pending     <= match_q.size();
        o_match_count <= match_count;
        o_bytes       <= bytes_in;
    end

endmodule

### dv/tb_masked_byte_signature_scanner.sv
// Testbench top for the masked byte signature scanner: clock, reset, pattern programming,
// byte stream stimulus with bursts and receiver stalls, watchdog and verdict.
// Depends on msbs_pkg, masked_byte_signature_scanner and msbs_match_checker.
module tb_masked_byte_signature_scanner;
    timeunit 1ns;
    timeprecision 1ps;
    import msbs_pkg::*;

    localparam int ADDR_W       = $clog2(2 * NUM_PATTERNS_DEF) + 3;
    localparam int NUM_PAT      = NUM_PATTERNS_DEF;
    localparam int MAX_LEN      = MAX_PATTERN_LEN_DEF;
    localparam int REG_BYTES    = 8;
    localparam int SIG_SEL      = 0;
    localparam int CTRL_SEL     = 1;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 12;
    localparam int MIN_MATCHES  = 48;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int match_count;
    int bytes_scanned;

    logic [CFG_DATA_W-1:0] cfg_sig  [NUM_PAT];
    logic [CTRL_W-1:0]     cfg_ctrl [NUM_PAT];
    int                    burst_left;
    int                    pattern_sets;
    int                    hold_requests;
    int                    holds_done;
    int                    idle_cycles;

    masked_byte_signature_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    msbs_match_checker #(.ADDR_W(ADDR_W)) u_match_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_match_count (match_count),
        .o_bytes       (bytes_scanned)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_item mk(logic [7:0] b, logic start);
        t_in_item it;
        it.data_byte    = b;
        it.buffer_start = start;
        return it;
    endfunction

    function automatic logic [CTRL_W-1:0] make_ctrl(int len, logic [7:0] wild);
        return CTRL_W'((len << LEN_LSB) | (int'(wild) << WILD_LSB));
    endfunction

    function automatic logic [7:0] noise_byte();
        int p;
        int j;
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p = $urandom_range(0, NUM_PAT - 1);
        j = $urandom_range(0, SIG_BYTES - 1);
        return cfg_sig[p][8*j +: 8];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_sig();
        logic [CFG_DATA_W-1:0] s;
        for (int j = 0; j < SIG_BYTES; j++) begin
            case ($urandom_range(0, 3))
                0:       s[8*j +: 8] = 8'h00;
                1:       s[8*j +: 8] = 8'hFF;
                2:       s[8*j +: 8] = 8'h41;
                default: s[8*j +: 8] = 8'($urandom);
            endcase
        end
        return s;
    endfunction

    task automatic send_item(t_in_item it, bit steady);
        int gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_access(bit wr, int idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx * REG_BYTES);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_patterns();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int p = 0; p < NUM_PAT; p++) begin
            apb_access(1'b1, 2 * p + SIG_SEL, cfg_sig[p]);
            apb_access(1'b1, 2 * p + CTRL_SEL, CFG_DATA_W'(cfg_ctrl[p]));
        end
        for (int r = 0; r < 2 * NUM_PAT; r++) apb_access(1'b0, r, '0);
        pattern_sets++;
    endtask

    task automatic random_patterns();
        int len;
        for (int p = 0; p < NUM_PAT; p++) begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(MAX_LEN + 1, 15);
                default: len = $urandom_range(1, MAX_LEN);
            endcase
            cfg_sig[p]  = random_sig();
            cfg_ctrl[p] = make_ctrl(len, $urandom_range(0, 1) ? 8'($urandom & $urandom) : 8'h00);
        end
    endtask

    // Mostly whole signatures with random wildcard bytes, some cut by a buffer start or a
    // flipped byte, the rest noise.
    task automatic stream_items(int count);
        int          sent;
        int          enabled [$];
        int          p;
        int          len;
        int          cut;
        logic [7:0]  b;
        logic        st;
        bit          start;
        sent = 0;
        enabled.delete();
        for (int q = 0; q < NUM_PAT; q++)
            if (cfg_ctrl[q][LEN_LSB +: LEN_FIELD_W] != 0) enabled = {enabled, q};
        while (sent < count) begin
            case ($urandom_range(0, 9)) inside
                [0:5]: begin
                    if (enabled.size() == 0) begin
                        send_item(mk(noise_byte(), 1'b0), 1'b0);
                        sent++;
                    end else begin
                        p     = enabled[$urandom_range(0, enabled.size() - 1)];
                        len   = int'(cfg_ctrl[p][LEN_LSB +: LEN_FIELD_W]);
                        len   = (len > MAX_LEN) ? MAX_LEN : len;
                        cut   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
                        start = ($urandom_range(0, 3) == 0);
                        for (int j = 0; j < len; j++) begin
                            b  = cfg_ctrl[p][WILD_LSB + j] ? 8'($urandom) : cfg_sig[p][8*j +: 8];
                            st = (j == 0) && start;
                            if (j == cut) begin
                                if ($urandom_range(0, 1)) st = 1'b1;
                                else b = ~b;
                            end
                            send_item(mk(b, st), 1'b0);
                            sent++;
                        end
                    end
                end
                [6:7]: begin
                    send_item(mk(noise_byte(), 1'b0), 1'b0);
                    sent++;
                end
                default: begin
                    send_item(mk(8'($urandom), $urandom_range(0, 7) == 0), 1'b0);
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_data     <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_requests <= 0;
        burst_left    = 0;
        pattern_sets  = 0;
        foreach (cfg_sig[p]) begin
            cfg_sig[p]  = '0;
            cfg_ctrl[p] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: registers read zero, every pattern off
        for (int r = 0; r < 2 * NUM_PAT; r++) apb_access(1'b0, r, '0);
        send_item(mk(8'h00, 1'b1), 1'b1);
        send_item(mk(8'hFF, 1'b0), 1'b1);
        send_item(mk(8'h00, 1'b0), 1'b1);

        // directed: eight 0xFF, FF-then-00, clamped all-wild length, single 0x00
        cfg_sig[0]  = '1;
        cfg_ctrl[0] = make_ctrl(MAX_LEN, 8'h00);
        cfg_sig[1]  = CFG_DATA_W'(16'h00FF);
        cfg_ctrl[1] = make_ctrl(2, 8'h00);
        cfg_sig[2]  = random_sig();
        cfg_ctrl[2] = '1;
        cfg_sig[3]  = '0;
        cfg_ctrl[3] = make_ctrl(1, 8'h00);
        load_patterns();
        send_item(mk(8'h00, 1'b1), 1'b1);
        repeat (8) send_item(mk(8'hFF, 1'b0), 1'b1);
        send_item(mk(8'h00, 1'b0), 1'b1);
        send_item(mk(8'hFF, 1'b1), 1'b1);
        repeat (7) send_item(mk(8'hFF, 1'b0), 1'b1);
        send_item(mk(8'h00, 1'b1), 1'b1);
        send_item(mk(8'hA5, 1'b0), 1'b1);
        send_item(mk(8'h5A, 1'b0), 1'b1);

        for (int ph = 0; ph < 5 || (match_count < MIN_MATCHES && ph < 12); ph++) begin
            case (ph)
                0: begin
                    foreach (cfg_sig[p]) begin
                        cfg_sig[p]  = random_sig();
                        cfg_ctrl[p] = make_ctrl(1, 8'hFF);
                    end
                end
                1: begin
                    cfg_sig[0]  = random_sig();
                    cfg_ctrl[0] = make_ctrl($urandom_range(1, 4), 8'($urandom & $urandom));
                    for (int p = 1; p < NUM_PAT; p++) begin
                        cfg_sig[p]  = cfg_sig[0];
                        cfg_ctrl[p] = cfg_ctrl[0];
                    end
                end
                2: begin
                    cfg_sig[0]  = '0;
                    cfg_ctrl[0] = make_ctrl(MAX_LEN, 8'h00);
                    cfg_sig[1]  = '1;
                    cfg_ctrl[1] = make_ctrl(MAX_LEN, 8'h00);
                    cfg_sig[2]  = random_sig();
                    cfg_ctrl[2] = '1;
                    cfg_sig[3]  = '1;
                    cfg_ctrl[3] = '0;
                end
                default: random_patterns();
            endcase
            load_patterns();
            if (ph == 0) begin
                // every byte gives four matches: hold the receiver and keep sending
                hold_requests <= hold_requests + 1;
                repeat (24) send_item(mk(8'($urandom), $urandom_range(0, 5) == 0), 1'b1);
                wait_drained();
                stream_items(8);
            end else begin
                stream_items(PHASE_ITEMS);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d bytes scanned, %0d matches checked over %0d pattern sets",
                 bytes_scanned, match_count, pattern_sets);
        $display("%0d long receiver holds, sender bursts and receiver stalls throughout",
                 holds_done);
        if (errors == 0 && pending == 0) begin
            $display("tb_masked_byte_signature_scanner: done, clean");
        end else begin
            $display("tb_masked_byte_signature_scanner: done, errors");
        end
        $finish;
    end

    initial begin
        int hold_left;
        int phase_left;
        int mode;
        int tick;
        hold_left   = 0;
        phase_left  = 0;
        mode        = 0;
        tick        = 0;
        holds_done  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(8, 64);
                end
                phase_left--;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 2) != 0);
                    default: i_out_stall <= tick[0];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_masked_byte_signature_scanner: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

### masked_byte_signature_scanner.f
rtl/core/msbs_pkg.sv
rtl/core/msbs_front.sv
rtl/core/msbs_fifo.sv
rtl/core/msbs_back.sv
rtl/core/masked_byte_signature_scanner.sv
dv/msbs_match_checker.sv
dv/tb_masked_byte_signature_scanner.sv
